FILE: rtl/line_segment_clipper_core_assert.svh
// Assertion macros used by the line segment clipper core.
`ifndef LINE_SEGMENT_CLIPPER_CORE_ASSERT_SVH
`define LINE_SEGMENT_CLIPPER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define LSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define LSC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/lsc_pkg.sv
// Shared constants and types for the line segment clipper.
`default_nettype none

package lsc_pkg;

    // Screen register width and clamp value
    localparam int SCREEN_BITS = 13;
    localparam logic [SCREEN_BITS-1:0] SCREEN_LIMIT = 13'd4096;
    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd480;

    // Output coordinate width (also the number of quotient bits)
    localparam int OUT_BITS = 12;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/lsc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module lsc_div_pipe
    import lsc_pkg::*;
#(
    parameter int NUM_W = 38,
    parameter int DEN_W = 18
)(
    input  wire                     clk,
    input  wire signed [NUM_W-1:0]  num,
    input  wire        [DEN_W-1:0]  den,
    output logic       [OUT_BITS-1:0] quo
);

    logic signed [NUM_W-1:0]    rem_reg [OUT_BITS-1];
    logic        [DEN_W-1:0]    den_reg [OUT_BITS-1];
    logic        [OUT_BITS-1:0] quo_reg [OUT_BITS];

    genvar i;
    generate
        for (i = 0; i < OUT_BITS; i++)
        begin : g_stage
            localparam int BIT = OUT_BITS - 1 - i;
            logic signed [NUM_W-1:0]    rem_in;
            logic signed [NUM_W-1:0]    sub;
            logic signed [NUM_W-1:0]    trial;
            logic        [DEN_W-1:0]    den_in;
            logic        [OUT_BITS-1:0] quo_in;

            if (i == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign den_in = den_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end

            // trial subtract of the shifted divisor
            assign sub   = signed'(NUM_W'(den_in) << BIT);
            assign trial = rem_in - sub;

            always_ff @(posedge clk)
            begin
                if (!trial[NUM_W-1])
                begin
                    quo_reg[i] <= quo_in | (OUT_BITS'(1) << BIT);
                end
                else
                begin
                    quo_reg[i] <= quo_in;
                end
            end

            if (i < OUT_BITS - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[i] <= trial[NUM_W-1] ? rem_in : trial;
                    den_reg[i] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[OUT_BITS-1];

endmodule

`default_nettype wire

FILE: rtl/line_segment_clipper_core.sv
// Top level of the Liang-Barsky line segment clipper.
`default_nettype none

// Usage:
// - Pulse start with a segment on start_x/start_y/end_x/end_y. busy is always
//   low, so a transaction is taken on every cycle that start is high.
// - Each segment yields one result through 7 clip stages, one stage per quotient
//   bit of the 12-bit rounding divider and one output register: done is high
//   for exactly one cycle with visible and the four clipped coordinates.
//   Throughput is one segment per cycle.
// - Rejected segments report visible low and all coordinates zero.
// - screen_width/screen_height are written through wr_en/wr_index/wr_data, by the user
//   only while no transaction is in flight; the block does not enforce this. Values above 4096 act as 4096.
// - Reset clears the pipeline valid bits and loads 800 x 480.
// - The receiver cannot stall; results are shown once and not held.
module line_segment_clipper_core
    import lsc_pkg::*;
#(
    parameter int COORD_BITS = 16
)(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [COORD_BITS-1:0]  start_x,
    input  wire signed [COORD_BITS-1:0]  start_y,
    input  wire signed [COORD_BITS-1:0]  end_x,
    input  wire signed [COORD_BITS-1:0]  end_y,
    input  wire                          wr_en,
    input  wire        [0:0]             wr_index,
    input  wire        [SCREEN_BITS-1:0] wr_data,
    output logic                         done,
    output logic                         visible,
    output logic       [OUT_BITS-1:0]    clipped_start_x,
    output logic       [OUT_BITS-1:0]    clipped_start_y,
    output logic       [OUT_BITS-1:0]    clipped_end_x,
    output logic       [OUT_BITS-1:0]    clipped_end_y
);

`include "line_segment_clipper_core_assert.svh"

    localparam int NW      = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 2;
    localparam int PW      = 2 * NW;
    localparam int RW      = 2 * NW + 2;
    localparam int EXT     = NW - COORD_BITS;
    localparam int LATENCY = 8 + OUT_BITS;
    localparam logic signed [NW-1:0] ONE = NW'(1);

    typedef struct packed {
        logic signed [NW-1:0] n;
        logic signed [NW-1:0] d;
    } ratio_t;

    typedef struct packed {
        logic   rej;
        ratio_t ent;
        ratio_t lvg;
    } bounds_t;

    // entering and leaving ratios of one axis against [0, lim]
    function automatic bounds_t axis_bounds(input logic signed [NW-1:0] a,
                                            input logic signed [NW-1:0] lim,
                                            input logic signed [NW-1:0] dir);
        bounds_t              r;
        logic signed [NW-1:0] q;
        q     = lim - a;
        r.rej = 1'b0;
        r.ent = '{n: '0, d: ONE};
        r.lvg = '{n: ONE, d: ONE};
        if (dir > 0)
        begin
            r.ent = '{n: -a, d: dir};
            r.lvg = '{n: q, d: dir};
        end
        else if (dir < 0)
        begin
            r.ent = '{n: -q, d: -dir};
            r.lvg = '{n: a, d: -dir};
        end
        else
        begin
            r.rej = a[NW-1] | q[NW-1];
        end
        return r;
    endfunction

    // configuration registers
    logic [SCREEN_BITS-1:0] width_reg;
    logic [SCREEN_BITS-1:0] height_reg;
    logic [SCREEN_BITS-1:0] width_cl;
    logic [SCREEN_BITS-1:0] height_cl;
    logic signed [NW-1:0]   xmax;
    logic signed [NW-1:0]   ymax;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_SCREEN_WIDTH:  width_reg  <= wr_data;
                REG_SCREEN_HEIGHT: height_reg <= wr_data;
            endcase
        end
    end

    assign width_cl  = (width_reg  > SCREEN_LIMIT) ? SCREEN_LIMIT : width_reg;
    assign height_cl = (height_reg > SCREEN_LIMIT) ? SCREEN_LIMIT : height_reg;
    assign xmax = $signed(NW'(width_cl))  - ONE;
    assign ymax = $signed(NW'(height_cl)) - ONE;

    assign busy = 1'b0;

    // valid bits
    logic v_s1_reg, v_s2_reg, v_s3_reg, v_s4_reg, v_s5_reg, v_s6_reg, v_s7_reg;
    logic v_dly_reg [OUT_BITS];
    logic done_reg;

    // stage payload
    logic signed [NW-1:0] x1_s1_reg, y1_s1_reg, dx_s1_reg, dy_s1_reg;
    logic signed [NW-1:0] x1_s2_reg, y1_s2_reg, dx_s2_reg, dy_s2_reg;
    logic signed [NW-1:0] x1_s3_reg, y1_s3_reg, dx_s3_reg, dy_s3_reg;
    logic signed [NW-1:0] x1_s4_reg, y1_s4_reg, dx_s4_reg, dy_s4_reg;
    logic signed [NW-1:0] x1_s5_reg, y1_s5_reg, dx_s5_reg, dy_s5_reg;
    logic signed [NW-1:0] sx_ext, sy_ext, ex_ext, ey_ext;
    bounds_t              bx_next, by_next, bx_s2_reg, by_s2_reg;
    ratio_t               en_x_next, en_y_next, lv_x_next, lv_y_next;
    ratio_t               en_x_s3_reg, en_y_s3_reg, lv_x_s3_reg, lv_y_s3_reg;
    ratio_t               en_x_s4_reg, en_y_s4_reg, lv_x_s4_reg, lv_y_s4_reg;
    logic signed [PW-1:0] pe_a_reg, pe_b_reg, pl_a_reg, pl_b_reg;
    ratio_t               t0_s5_reg, t1_s5_reg;
    logic signed [NW:0]   x2p1, y2p1;
    logic signed [PW-1:0] ca_reg, cb_reg;
    logic signed [PW-1:0] m_reg [4];
    logic signed [PW:0]   b_reg [4];
    logic signed [NW-1:0] t0d_s6_reg, t1d_s6_reg;
    logic signed [RW-1:0] num_s7_reg [4];
    logic        [NW-1:0] den_s7_reg [4];
    logic                 rej_s3_reg, rej_s4_reg, rej_s5_reg, rej_s6_reg, rej_s7_reg;
    logic                 rej_dly_reg [OUT_BITS];
    logic [OUT_BITS-1:0]  quo [4];
    logic                 vis_reg;
    logic [OUT_BITS-1:0]  csx_reg, csy_reg, cex_reg, cey_reg;

    assign sx_ext = {{EXT{start_x[COORD_BITS-1]}}, start_x};
    assign sy_ext = {{EXT{start_y[COORD_BITS-1]}}, start_y};
    assign ex_ext = {{EXT{end_x[COORD_BITS-1]}}, end_x};
    assign ey_ext = {{EXT{end_y[COORD_BITS-1]}}, end_y};

    // ratios of the four screen borders, then clamp to the [0, 1] window
    assign bx_next = axis_bounds(x1_s1_reg, xmax, dx_s1_reg);
    assign by_next = axis_bounds(y1_s1_reg, ymax, dy_s1_reg);

    always_comb
    begin
        en_x_next = bx_s2_reg.ent;
        en_y_next = by_s2_reg.ent;
        lv_x_next = bx_s2_reg.lvg;
        lv_y_next = by_s2_reg.lvg;
        if (en_x_next.n < 0)
        begin
            en_x_next = '{n: '0, d: ONE};
        end
        if (en_y_next.n < 0)
        begin
            en_y_next = '{n: '0, d: ONE};
        end
        if (lv_x_next.n > lv_x_next.d)
        begin
            lv_x_next = '{n: ONE, d: ONE};
        end
        if (lv_y_next.n > lv_y_next.d)
        begin
            lv_y_next = '{n: ONE, d: ONE};
        end
    end

    assign x2p1 = $signed({x1_s5_reg, 1'b1});
    assign y2p1 = $signed({y1_s5_reg, 1'b1});

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg <= 1'b0;
            v_s2_reg <= 1'b0;
            v_s3_reg <= 1'b0;
            v_s4_reg <= 1'b0;
            v_s5_reg <= 1'b0;
            v_s6_reg <= 1'b0;
            v_s7_reg <= 1'b0;
            for (int k = 0; k < OUT_BITS; k++)
            begin
                v_dly_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            v_s1_reg <= start & ~busy;
            v_s2_reg <= v_s1_reg;
            v_s3_reg <= v_s2_reg;
            v_s4_reg <= v_s3_reg;
            v_s5_reg <= v_s4_reg;
            v_s6_reg <= v_s5_reg;
            v_s7_reg <= v_s6_reg;
            v_dly_reg[0] <= v_s7_reg;
            for (int k = 1; k < OUT_BITS; k++)
            begin
                v_dly_reg[k] <= v_dly_reg[k-1];
            end
            done_reg <= v_dly_reg[OUT_BITS-1];
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        // stage 1: direction
        x1_s1_reg <= sx_ext;
        y1_s1_reg <= sy_ext;
        dx_s1_reg <= ex_ext - sx_ext;
        dy_s1_reg <= ey_ext - sy_ext;
        // stage 2: edge ratios
        bx_s2_reg <= bx_next;
        by_s2_reg <= by_next;
        x1_s2_reg <= x1_s1_reg;
        y1_s2_reg <= y1_s1_reg;
        dx_s2_reg <= dx_s1_reg;
        dy_s2_reg <= dy_s1_reg;
        // stage 3: clamp
        en_x_s3_reg <= en_x_next;
        en_y_s3_reg <= en_y_next;
        lv_x_s3_reg <= lv_x_next;
        lv_y_s3_reg <= lv_y_next;
        rej_s3_reg  <= bx_s2_reg.rej | by_s2_reg.rej;
        x1_s3_reg   <= x1_s2_reg;
        y1_s3_reg   <= y1_s2_reg;
        dx_s3_reg   <= dx_s2_reg;
        dy_s3_reg   <= dy_s2_reg;
        // stage 4: cross products between axes
        pe_a_reg    <= en_x_s3_reg.n * en_y_s3_reg.d;
        pe_b_reg    <= en_y_s3_reg.n * en_x_s3_reg.d;
        pl_a_reg    <= lv_x_s3_reg.n * lv_y_s3_reg.d;
        pl_b_reg    <= lv_y_s3_reg.n * lv_x_s3_reg.d;
        en_x_s4_reg <= en_x_s3_reg;
        en_y_s4_reg <= en_y_s3_reg;
        lv_x_s4_reg <= lv_x_s3_reg;
        lv_y_s4_reg <= lv_y_s3_reg;
        rej_s4_reg  <= rej_s3_reg;
        x1_s4_reg   <= x1_s3_reg;
        y1_s4_reg   <= y1_s3_reg;
        dx_s4_reg   <= dx_s3_reg;
        dy_s4_reg   <= dy_s3_reg;
        // stage 5: t0 = max of entering, t1 = min of leaving
        t0_s5_reg  <= (pe_a_reg >= pe_b_reg) ? en_x_s4_reg : en_y_s4_reg;
        t1_s5_reg  <= (pl_a_reg <= pl_b_reg) ? lv_x_s4_reg : lv_y_s4_reg;
        rej_s5_reg <= rej_s4_reg;
        x1_s5_reg  <= x1_s4_reg;
        y1_s5_reg  <= y1_s4_reg;
        dx_s5_reg  <= dx_s4_reg;
        dy_s5_reg  <= dy_s4_reg;
        // stage 6: window check and rounding products
        ca_reg     <= t0_s5_reg.n * t1_s5_reg.d;
        cb_reg     <= t1_s5_reg.n * t0_s5_reg.d;
        m_reg[0]   <= t0_s5_reg.n * dx_s5_reg;
        m_reg[1]   <= t0_s5_reg.n * dy_s5_reg;
        m_reg[2]   <= t1_s5_reg.n * dx_s5_reg;
        m_reg[3]   <= t1_s5_reg.n * dy_s5_reg;
        b_reg[0]   <= t0_s5_reg.d * x2p1;
        b_reg[1]   <= t0_s5_reg.d * y2p1;
        b_reg[2]   <= t1_s5_reg.d * x2p1;
        b_reg[3]   <= t1_s5_reg.d * y2p1;
        t0d_s6_reg <= t0_s5_reg.d;
        t1d_s6_reg <= t1_s5_reg.d;
        rej_s6_reg <= rej_s5_reg;
        // stage 7: empty window rejects; dividend 2*n*delta + den*(2a+1)
        rej_s7_reg <= rej_s6_reg | (ca_reg > cb_reg);
        for (int k = 0; k < 4; k++)
        begin
            num_s7_reg[k] <= (RW'(m_reg[k]) <<< 1) + RW'(b_reg[k]);
        end
        den_s7_reg[0] <= {t0d_s6_reg[NW-2:0], 1'b0};
        den_s7_reg[1] <= {t0d_s6_reg[NW-2:0], 1'b0};
        den_s7_reg[2] <= {t1d_s6_reg[NW-2:0], 1'b0};
        den_s7_reg[3] <= {t1d_s6_reg[NW-2:0], 1'b0};
        // reject flag alongside the divider
        rej_dly_reg[0] <= rej_s7_reg;
        for (int k = 1; k < OUT_BITS; k++)
        begin
            rej_dly_reg[k] <= rej_dly_reg[k-1];
        end
        // output register
        vis_reg <= ~rej_dly_reg[OUT_BITS-1];
        csx_reg <= rej_dly_reg[OUT_BITS-1] ? '0 : quo[0];
        csy_reg <= rej_dly_reg[OUT_BITS-1] ? '0 : quo[1];
        cex_reg <= rej_dly_reg[OUT_BITS-1] ? '0 : quo[2];
        cey_reg <= rej_dly_reg[OUT_BITS-1] ? '0 : quo[3];
    end

    // rounding dividers, one per output coordinate
    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_div
            lsc_div_pipe #(
                .NUM_W (RW),
                .DEN_W (NW)
            ) u_div (
                .clk (clk),
                .num (num_s7_reg[g]),
                .den (den_s7_reg[g]),
                .quo (quo[g])
            );
        end
    endgenerate

    assign done            = done_reg;
    assign visible         = vis_reg;
    assign clipped_start_x = csx_reg;
    assign clipped_start_y = csy_reg;
    assign clipped_end_x   = cex_reg;
    assign clipped_end_y   = cey_reg;

    // summary terms for the checks
    logic coords_zero;
    logic coords_on_screen;

    assign coords_zero = (clipped_start_x == '0) && (clipped_start_y == '0)
                      && (clipped_end_x == '0) && (clipped_end_y == '0);
    assign coords_on_screen = ({1'b0, clipped_start_x} < width_cl)
                           && ({1'b0, clipped_end_x} < width_cl)
                           && ({1'b0, clipped_start_y} < height_cl)
                           && ({1'b0, clipped_end_y} < height_cl);

    // checks
    `LSC_ASSERT_IMP(a_fixed_latency, start, ##LATENCY done, "result latency mismatch")
    `LSC_ASSERT_NEVER(a_reject_zero, done && !visible && !coords_zero, "reject not zeroed")
    `LSC_ASSERT_IMP(a_on_screen, done && visible, coords_on_screen, "clipped point off screen")

endmodule

`default_nettype wire

FILE: tb/line_segment_clipper_checker.sv
// Checker for the line segment clipper: predicts each clipped segment and compares results.
`timescale 1ns / 1ps

module line_segment_clipper_checker
    import lsc_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire                   busy,
    input  wire signed [15:0]     start_x,
    input  wire signed [15:0]     start_y,
    input  wire signed [15:0]     end_x,
    input  wire signed [15:0]     end_y,
    input  wire                   wr_en,
    input  wire [0:0]             wr_index,
    input  wire [SCREEN_BITS-1:0] wr_data,
    input  wire                   done,
    input  wire                   visible,
    input  wire [OUT_BITS-1:0]    clipped_start_x,
    input  wire [OUT_BITS-1:0]    clipped_start_y,
    input  wire [OUT_BITS-1:0]    clipped_end_x,
    input  wire [OUT_BITS-1:0]    clipped_end_y,
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct packed {
        logic                vis;
        logic [OUT_BITS-1:0] sx;
        logic [OUT_BITS-1:0] sy;
        logic [OUT_BITS-1:0] ex;
        logic [OUT_BITS-1:0] ey;
    } clip_result_t;

    logic [SCREEN_BITS-1:0] width_model;
    logic [SCREEN_BITS-1:0] height_model;
    clip_result_t expected_clips[$];

    // Narrow the window [n0/d0, n1/d1] by one edge; returns 0 on reject
    function automatic bit narrow_edge(longint p, longint q, inout longint n0,
                                       inout longint d0, inout longint n1,
                                       inout longint d1);
        longint rn;
        longint rd;
        if (p == 0) return q >= 0;
        if (p < 0) begin rn = -q; rd = -p; end else begin rn = q; rd = p; end
        if (p < 0) begin
            if (rn * d1 > n1 * rd) return 0;
            if (rn * d0 > n0 * rd) begin n0 = rn; d0 = rd; end
        end else begin
            if (rn * d0 < n0 * rd) return 0;
            if (rn * d1 < n1 * rd) begin n1 = rn; d1 = rd; end
        end
        return 1;
    endfunction

    // floor(a + (n/den)*delta + 1/2) = floor((2*a*den + 2*n*delta + den) / (2*den))
    function automatic logic [OUT_BITS-1:0] round_coord(longint a, longint n,
                                                        longint den, longint delta);
        longint num;
        longint dv;
        longint quo;
        num = 2 * a * den + 2 * n * delta + den;
        dv  = 2 * den;
        quo = num / dv;
        if ((num % dv != 0) && (num < 0)) quo = quo - 1;
        return quo[OUT_BITS-1:0];
    endfunction

    function automatic clip_result_t clip_segment(longint x1, longint y1,
                                                  longint x2, longint y2);
        clip_result_t r;
        longint w, h, dx, dy, n0, d0, n1, d1;
        bit ok;
        w  = (width_model > SCREEN_LIMIT) ? SCREEN_LIMIT : width_model;
        h  = (height_model > SCREEN_LIMIT) ? SCREEN_LIMIT : height_model;
        dx = x2 - x1;
        dy = y2 - y1;
        n0 = 0; d0 = 1; n1 = 1; d1 = 1;
        ok = narrow_edge(-dx, x1, n0, d0, n1, d1);
        if (ok) ok = narrow_edge(dx, w - 1 - x1, n0, d0, n1, d1);
        if (ok) ok = narrow_edge(-dy, y1, n0, d0, n1, d1);
        if (ok) ok = narrow_edge(dy, h - 1 - y1, n0, d0, n1, d1);
        r = '0;
        if (ok) begin
            r.vis = 1'b1;
            r.sx  = round_coord(x1, n0, d0, dx);
            r.sy  = round_coord(y1, n0, d0, dy);
            r.ex  = round_coord(x1, n1, d1, dx);
            r.ey  = round_coord(y1, n1, d1, dy);
        end
        return r;
    endfunction

    // Track register writes, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        clip_result_t want;
        clip_result_t got;
        if (!rst_n)
        begin
            width_model = WIDTH_RESET;
            height_model = HEIGHT_RESET;
            fail_count = 0;
            expected_clips.delete();
            pending_count = 0;
        end
        else
        begin
            if (done)
            begin
                got = {visible, clipped_start_x, clipped_start_y,
                       clipped_end_x, clipped_end_y};
                if (expected_clips.size() == 0)
                begin
                    $display("%0t: unexpected result vis=%0d %0d,%0d %0d,%0d", $time,
                             got.vis, got.sx, got.sy, got.ex, got.ey);
                    fail_count++;
                end
                else
                begin
                    want = expected_clips.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: mismatch expected vis=%0d %0d,%0d %0d,%0d",
                                 $time, want.vis, want.sx, want.sy, want.ex, want.ey);
                        $display("%0t:          actual   vis=%0d %0d,%0d %0d,%0d",
                                 $time, got.vis, got.sx, got.sy, got.ex, got.ey);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_clips.push_back(clip_segment(start_x, start_y, end_x, end_y));
            if (wr_en)
            begin
                if (wr_index == REG_SCREEN_WIDTH) width_model = wr_data;
                else height_model = wr_data;
            end
            pending_count = expected_clips.size();
        end
    end

endmodule

FILE: tb/tb_line_segment_clipper_core.sv
// Testbench top for the line segment clipper: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb_line_segment_clipper_core;
    import lsc_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic wr_en = 1'b0;
    logic [0:0] wr_index = REG_SCREEN_WIDTH;
    logic [SCREEN_BITS-1:0] wr_data = '0;
    logic done, visible;
    logic [OUT_BITS-1:0] clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
    int fail_count, pending_count;
    int cycle_count = 0;
    int idle_pct = 0;
    logic [SCREEN_BITS-1:0] cur_w = WIDTH_RESET, cur_h = HEIGHT_RESET;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    line_segment_clipper_core u_dut (.*);

    line_segment_clipper_checker u_checker (.*);

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One segment transaction, with random sender gaps before it;
    // called just after the clock rises, returns just after the clock that accepts it
    task automatic send_segment(input int ax, ay, bx, by);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        start_x <= 16'(ax);
        start_y <= 16'(ay);
        end_x   <= 16'(bx);
        end_y   <= 16'(by);
        do @(posedge clk); while (busy);
    endtask

    task automatic write_screen(input cfg_index_t idx, input logic [SCREEN_BITS-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_SCREEN_WIDTH) cur_w = val; else cur_h = val;
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Coordinate near the screen most of the time, any value sometimes
    function automatic logic signed [15:0] pick_coord(input logic [SCREEN_BITS-1:0] lim);
        case ($urandom_range(9, 0))
            0, 1:    return 16'($urandom);
            2:       return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
            3:       return 16'(int'(lim) - 1 + int'($urandom_range(4, 0)) - 2);
            default: return 16'(int'($urandom_range(lim + 200, 0)) - 100);
        endcase
    endfunction

    task automatic random_phase(input int count, input int pct);
        idle_pct = pct;
        repeat (count)
            send_segment(pick_coord(cur_w), pick_coord(cur_h),
                         pick_coord(cur_w), pick_coord(cur_h));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, degenerate points, edge ties, full crossings
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_segment(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_segment(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_segment(10, 20, 10, 20);
        send_segment(799, 479, 799, 479);
        send_segment(800, 10, 800, 10);
        send_segment(0, 0, 799, 479);
        send_segment(-100, 5, 900, 5);
        send_segment(5, -100, 5, 600);
        send_segment(-1, 0, -1, 479);
        send_segment(-10, -10, -1, -1);
        send_segment(-5, 5, 5, -5);
        send_segment(100, 600, 900, -50);
        send_segment(-16'sd1, 16'sh7fff, 16'sh5555, -16'sh2aab);
        drain_pipeline();

        // Zero screen rejects everything
        write_screen(REG_SCREEN_WIDTH, 13'd0);
        write_screen(REG_SCREEN_HEIGHT, 13'd0);
        send_segment(0, 0, 0, 0);
        send_segment(-5, -5, 5, 5);
        drain_pipeline();

        // Oversized registers clamp to the limit
        write_screen(REG_SCREEN_WIDTH, 13'h1fff);
        write_screen(REG_SCREEN_HEIGHT, 13'd4097);
        send_segment(16'sh8000, 4095, 16'sh7fff, 4095);
        send_segment(4096, 0, 4095, 4095);
        random_phase(150, 36);
        drain_pipeline();

        write_screen(REG_SCREEN_WIDTH, 13'd1);
        write_screen(REG_SCREEN_HEIGHT, 13'd1);
        random_phase(150, 36);
        drain_pipeline();

        write_screen(REG_SCREEN_WIDTH, 13'd4096);
        write_screen(REG_SCREEN_HEIGHT, 13'd3);
        random_phase(200, 55);
        drain_pipeline();

        write_screen(REG_SCREEN_WIDTH, 13'd640);
        write_screen(REG_SCREEN_HEIGHT, 13'd4096);
        random_phase(300, 55);
        drain_pipeline();

        write_screen(REG_SCREEN_WIDTH, 13'($urandom_range(4096, 1)));
        write_screen(REG_SCREEN_HEIGHT, 13'($urandom_range(4096, 1)));
        random_phase(400, 0);
        drain_pipeline();

        write_screen(REG_SCREEN_WIDTH, WIDTH_RESET);
        write_screen(REG_SCREEN_HEIGHT, HEIGHT_RESET);
        random_phase(300, 0);
        drain_pipeline();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
